// ===== rtl/core/pcd_pkg.sv =====
// Package for the page cache directory: request, response and line types,
// codes and sizing constants. No dependencies.
package pcd_pkg;

    localparam int LINES        = 16;
    localparam int IDX_W        = $clog2(LINES);
    localparam int CNT_W        = IDX_W + 1;
    localparam int LINE_INDEX_W = 4;
    localparam int PAGE_W       = 32;
    localparam int AGE_W        = 32;
    localparam int USERS_W      = 16;
    localparam int PERIOD_W     = 8;

    localparam logic [PAGE_W-1:0]  NULL_PAGE = '1;
    localparam logic [USERS_W-1:0] USERS_MAX = '1;

    // request actions
    localparam logic [1:0] ACT_GET   = 2'd0;
    localparam logic [1:0] ACT_PUT   = 2'd1;
    localparam logic [1:0] ACT_CLEAR = 2'd2;
    localparam logic [1:0] ACT_NOP   = 2'd3;

    // response status codes
    localparam logic [1:0] ST_OK         = 2'd0;
    localparam logic [1:0] ST_MISS       = 2'd1;
    localparam logic [1:0] ST_NULL_PAGE  = 2'd2;
    localparam logic [1:0] ST_NOT_CACHED = 2'd3;

    // replacement policies
    localparam logic [1:0] POL_BYPASS = 2'd0;
    localparam logic [1:0] POL_FIFO   = 2'd1;
    localparam logic [1:0] POL_NFU    = 2'd2;
    localparam logic [1:0] POL_AGING  = 2'd3;

    // configuration register indexes
    localparam logic REG_POLICY = 1'b0;
    localparam logic REG_PERIOD = 1'b1;

    typedef struct packed {
        logic [1:0]        action;
        logic [PAGE_W-1:0] page_number;
    } req_t;

    typedef struct packed {
        logic [1:0]              status;
        logic [LINE_INDEX_W-1:0] line_index;
        logic                    writeback_valid;
        logic [PAGE_W-1:0]       writeback_page;
        logic                    fetch_valid;
        logic [31:0]             hit_count;
        logic [31:0]             miss_count;
    } rsp_t;

    typedef struct packed {
        logic [PAGE_W-1:0]  tag;
        logic [AGE_W-1:0]   age;
        logic               referenced;
        logic [USERS_W-1:0] users;
    } line_t;

    localparam line_t LINE_RESET = '{tag: NULL_PAGE, age: '0, referenced: 1'b0, users: '0};

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_UPDATE,
        S_WAIT_DIV,
        S_SWEEP,
        S_RESP
    } state_e;

endpackage

// ===== rtl/core/pcd_line_ram.sv =====
// Line state memory: one write port, one registered read port.
// Depends on pcd_pkg; per-entry valid bits make unwritten lines read as reset.
module pcd_line_ram (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 wr_en,
    input  logic [pcd_pkg::IDX_W-1:0] wr_addr,
    input  pcd_pkg::line_t       wr_data,
    input  logic                 rd_en,
    input  logic [pcd_pkg::IDX_W-1:0] rd_addr,
    output pcd_pkg::line_t       rd_data
);
    import pcd_pkg::*;

    line_t             mem [LINES];
    logic [LINES-1:0]  vld_reg;
    line_t             rd_data_reg;

    // storage array
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // valid bits, cleared by reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (wr_en)
        begin
            vld_reg[wr_addr] <= 1'b1;
        end
    end

    // registered read
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= vld_reg[rd_addr] ? mem[rd_addr] : LINE_RESET;
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== rtl/core/pcd_mod_unit.sv =====
// Bit-serial remainder unit: dividend mod divisor, one quotient bit a cycle.
// Depends on pcd_pkg.
module pcd_mod_unit (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  logic [31:0]                  dividend,
    input  logic [pcd_pkg::PERIOD_W-1:0] divisor,
    output logic                         done,
    output logic [pcd_pkg::PERIOD_W-1:0] remainder
);
    import pcd_pkg::*;

    logic [31:0]         num_reg, num_next;
    logic [PERIOD_W-1:0] div_reg, div_next;
    logic [PERIOD_W-1:0] rem_reg, rem_next;
    logic [5:0]          cnt_reg, cnt_next;
    logic [PERIOD_W:0]   trial;

    // one restoring step per cycle
    always_comb
    begin
        num_next = num_reg;
        div_next = div_reg;
        rem_next = rem_reg;
        cnt_next = cnt_reg;
        trial    = {rem_reg, num_reg[31]};
        if (start)
        begin
            num_next = dividend;
            div_next = divisor;
            rem_next = '0;
            cnt_next = 6'd32;
        end
        else if (cnt_reg != 6'd0)
        begin
            if (trial >= {1'b0, div_reg})
            begin
                trial = trial - {1'b0, div_reg};
            end
            rem_next = trial[PERIOD_W-1:0];
            num_next = {num_reg[30:0], 1'b0};
            cnt_next = cnt_reg - 6'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        num_reg <= num_next;
        div_reg <= div_next;
        rem_reg <= rem_next;
    end

    assign done      = (cnt_reg == 6'd0);
    assign remainder = rem_reg;

endmodule

// ===== rtl/core/page_cache_directory_replacement_top.sv =====
// Page cache directory top: sequencer around the line memory and mod unit.
// A put scans all LINES tags and may update a line; a get also waits on the
// remainder unit and, under nfu or aging each period-th get, sweeps all ages.
// Clear, null page and nop go straight to the response. All may wait on
// rsp_ready. Throughput: one request at a time. Reset clears all lines to
// empty, counters to zero, policy to fifo and period to 1 at once (memory valid bits).
module page_cache_directory_replacement_top (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     req_valid,
    output logic                     req_ready,
    input  pcd_pkg::req_t            req,
    output logic                     rsp_valid,
    input  logic                     rsp_ready,
    output pcd_pkg::rsp_t            rsp,
    input  logic                     cfg_valid,
    output logic                     cfg_ready,
    input  logic                     cfg_index,
    input  logic [7:0]               cfg_data
);
    import pcd_pkg::*;

    state_e             state_reg, state_next;
    req_t               req_reg, req_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic               pvld_reg, pvld_next;
    logic [IDX_W-1:0]   pidx_reg, pidx_next;
    logic               mfound_reg, mfound_next;
    logic [IDX_W-1:0]   midx_reg, midx_next;
    line_t              mline_reg, mline_next;
    logic               efound_reg, efound_next;
    logic [IDX_W-1:0]   eidx_reg, eidx_next;
    logic [IDX_W-1:0]   minidx_reg, minidx_next;
    line_t              minline_reg, minline_next;
    line_t              line0_reg, line0_next;
    logic [31:0]        get_cnt_reg, get_cnt_next;
    logic [31:0]        hit_reg, hit_next;
    logic [31:0]        miss_reg, miss_next;
    logic [1:0]         policy_reg, policy_next;
    logic [PERIOD_W-1:0] period_reg, period_next;
    rsp_t               res_reg, res_next;
    rsp_t               rsp_reg, rsp_next;
    logic               out_valid_reg, out_valid_next;

    logic               accept;
    logic               is_page_op;
    logic               out_free;
    logic               age_policy;
    logic               div_start;
    logic               div_done;
    logic [PERIOD_W-1:0] div_rem;
    logic [PERIOD_W-1:0] divisor;

    logic               wr_en;
    logic [IDX_W-1:0]   wr_addr;
    line_t              wr_data;
    logic               rd_en;
    logic [IDX_W-1:0]   rd_addr;
    line_t              rd_data;

    logic [IDX_W-1:0]   victim;
    logic [PAGE_W-1:0]  victim_tag;
    line_t              upd;

    assign req_ready  = (state_reg == S_IDLE);
    assign accept     = req_valid && req_ready;
    assign cfg_ready  = 1'b1;
    assign rsp_valid  = out_valid_reg;
    assign rsp        = rsp_reg;
    assign out_free   = !out_valid_reg || rsp_ready;
    assign is_page_op = (req.page_number != NULL_PAGE) &&
                        ((req.action == ACT_GET) || (req.action == ACT_PUT));
    assign age_policy = (policy_reg == POL_NFU) || (policy_reg == POL_AGING);
    assign divisor    = (period_reg == '0) ? PERIOD_W'(1) : period_reg;
    assign div_start  = accept && is_page_op && (req.action == ACT_GET);

    pcd_line_ram u_ram (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    pcd_mod_unit u_mod (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (get_cnt_reg + 32'd1),
        .divisor   (divisor),
        .done      (div_done),
        .remainder (div_rem)
    );

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = is_page_op ? S_SCAN : S_RESP;
                end
            end
            S_SCAN:
            begin
                if ((cnt_reg == CNT_W'(LINES)) && !pvld_reg)
                begin
                    state_next = S_UPDATE;
                end
            end
            S_UPDATE:
            begin
                state_next = (req_reg.action == ACT_GET) ? S_WAIT_DIV : S_RESP;
            end
            S_WAIT_DIV:
            begin
                if (div_done)
                begin
                    state_next = ((div_rem == '0) && age_policy) ? S_SWEEP : S_RESP;
                end
            end
            S_SWEEP:
            begin
                if ((cnt_reg == CNT_W'(LINES)) && !pvld_reg)
                begin
                    state_next = S_RESP;
                end
            end
            S_RESP:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // victim choice for a get miss
    always_comb
    begin
        if (policy_reg == POL_BYPASS)
        begin
            victim     = '0;
            victim_tag = line0_reg.tag;
        end
        else if (efound_reg)
        begin
            victim     = eidx_reg;
            victim_tag = NULL_PAGE;
        end
        else
        begin
            victim     = minidx_reg;
            victim_tag = minline_reg.tag;
        end
    end

    // datapath and memory control
    always_comb
    begin
        req_next       = req_reg;
        cnt_next       = cnt_reg;
        pvld_next      = 1'b0;
        pidx_next      = pidx_reg;
        mfound_next    = mfound_reg;
        midx_next      = midx_reg;
        mline_next     = mline_reg;
        efound_next    = efound_reg;
        eidx_next      = eidx_reg;
        minidx_next    = minidx_reg;
        minline_next   = minline_reg;
        line0_next     = line0_reg;
        get_cnt_next   = get_cnt_reg;
        hit_next       = hit_reg;
        miss_next      = miss_reg;
        policy_next    = policy_reg;
        period_next    = period_reg;
        res_next       = res_reg;
        rsp_next       = rsp_reg;
        out_valid_next = out_valid_reg;
        wr_en          = 1'b0;
        wr_addr        = pidx_reg;
        wr_data        = rd_data;
        rd_en          = 1'b0;
        rd_addr        = cnt_reg[IDX_W-1:0];
        upd            = mline_reg;

        // configuration writes
        if (cfg_valid)
        begin
            case (cfg_index)
                REG_POLICY: policy_next = cfg_data[1:0];
                REG_PERIOD: period_next = cfg_data;
                default:    period_next = period_reg;
            endcase
        end

        // output register drains
        if (out_valid_reg && rsp_ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    req_next    = req;
                    cnt_next    = '0;
                    mfound_next = 1'b0;
                    efound_next = 1'b0;
                    res_next    = '0;
                    if (req.action == ACT_CLEAR)
                    begin
                        hit_next  = '0;
                        miss_next = '0;
                    end
                    else if (!is_page_op && (req.action != ACT_NOP))
                    begin
                        // get or put of the null page
                        res_next.status = ST_NULL_PAGE;
                    end
                end
            end
            S_SCAN:
            begin
                // issue reads
                if (cnt_reg != CNT_W'(LINES))
                begin
                    rd_en     = 1'b1;
                    cnt_next  = cnt_reg + CNT_W'(1);
                    pvld_next = 1'b1;
                    pidx_next = cnt_reg[IDX_W-1:0];
                end
                // compare returned line
                if (pvld_reg)
                begin
                    if (!mfound_reg && (rd_data.tag == req_reg.page_number))
                    begin
                        mfound_next = 1'b1;
                        midx_next   = pidx_reg;
                        mline_next  = rd_data;
                    end
                    if (!efound_reg && (rd_data.tag == NULL_PAGE))
                    begin
                        efound_next = 1'b1;
                        eidx_next   = pidx_reg;
                    end
                    if ((pidx_reg == '0) || (rd_data.age < minline_reg.age))
                    begin
                        minidx_next  = pidx_reg;
                        minline_next = rd_data;
                    end
                    if (pidx_reg == '0)
                    begin
                        line0_next = rd_data;
                    end
                end
            end
            S_UPDATE:
            begin
                wr_en = 1'b0;
                if (req_reg.action == ACT_GET)
                begin
                    wr_en        = 1'b1;
                    get_cnt_next = get_cnt_reg + 32'd1;
                    if (mfound_reg)
                    begin
                        upd      = mline_reg;
                        wr_addr  = midx_reg;
                        hit_next = hit_reg + 32'd1;
                        res_next.status     = ST_OK;
                        res_next.line_index = LINE_INDEX_W'(midx_reg);
                    end
                    else
                    begin
                        upd.tag   = req_reg.page_number;
                        upd.users = '0;
                        upd.age   = age_policy ? '0 : get_cnt_reg;
                        wr_addr   = victim;
                        miss_next = miss_reg + 32'd1;
                        res_next.status          = ST_MISS;
                        res_next.line_index      = LINE_INDEX_W'(victim);
                        res_next.fetch_valid     = 1'b1;
                        res_next.writeback_valid = (victim_tag != NULL_PAGE);
                        res_next.writeback_page  = (victim_tag != NULL_PAGE) ? victim_tag : '0;
                    end
                    upd.referenced = 1'b1;
                    if (upd.users != USERS_MAX)
                    begin
                        upd.users = upd.users + USERS_W'(1);
                    end
                    wr_data = upd;
                end
                else if (mfound_reg)
                begin
                    // put of a cached page
                    upd     = mline_reg;
                    wr_en   = 1'b1;
                    wr_addr = midx_reg;
                    if (mline_reg.users != '0)
                    begin
                        upd.users = mline_reg.users - USERS_W'(1);
                    end
                    wr_data = upd;
                    res_next.status          = ST_OK;
                    res_next.line_index      = LINE_INDEX_W'(midx_reg);
                    res_next.writeback_valid = (mline_reg.users == USERS_W'(1));
                    res_next.writeback_page  =
                        (mline_reg.users == USERS_W'(1)) ? mline_reg.tag : '0;
                end
                else
                begin
                    res_next.status = ST_NOT_CACHED;
                end
                cnt_next = '0;
            end
            S_WAIT_DIV:
            begin
                cnt_next = '0;
            end
            S_SWEEP:
            begin
                // read line i while writing back line i-1
                if (cnt_reg != CNT_W'(LINES))
                begin
                    rd_en     = 1'b1;
                    cnt_next  = cnt_reg + CNT_W'(1);
                    pvld_next = 1'b1;
                    pidx_next = cnt_reg[IDX_W-1:0];
                end
                if (pvld_reg)
                begin
                    upd = rd_data;
                    if (policy_reg == POL_AGING)
                    begin
                        upd.age = {rd_data.referenced, rd_data.age[AGE_W-1:1]};
                    end
                    else if (rd_data.referenced)
                    begin
                        upd.age = rd_data.age + AGE_W'(1);
                    end
                    upd.referenced = 1'b0;
                    wr_en   = 1'b1;
                    wr_addr = pidx_reg;
                    wr_data = upd;
                end
            end
            S_RESP:
            begin
                if (out_free)
                begin
                    rsp_next            = res_reg;
                    rsp_next.hit_count  = hit_reg;
                    rsp_next.miss_count = miss_reg;
                    out_valid_next      = 1'b1;
                end
            end
            default:
            begin
                cnt_next = '0;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            pvld_reg      <= 1'b0;
            cnt_reg       <= '0;
            get_cnt_reg   <= '0;
            hit_reg       <= '0;
            miss_reg      <= '0;
            policy_reg    <= POL_FIFO;
            period_reg    <= PERIOD_W'(1);
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            pvld_reg      <= pvld_next;
            cnt_reg       <= cnt_next;
            get_cnt_reg   <= get_cnt_next;
            hit_reg       <= hit_next;
            miss_reg      <= miss_next;
            policy_reg    <= policy_next;
            period_reg    <= period_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        req_reg     <= req_next;
        pidx_reg    <= pidx_next;
        mfound_reg  <= mfound_next;
        midx_reg    <= midx_next;
        mline_reg   <= mline_next;
        efound_reg  <= efound_next;
        eidx_reg    <= eidx_next;
        minidx_reg  <= minidx_next;
        minline_reg <= minline_next;
        line0_reg   <= line0_next;
        res_reg     <= res_next;
        rsp_reg     <= rsp_next;
    end

endmodule
